>>> sv/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// Shared constants and types for the Catmull-Rom derivative evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package crd_pkg;

    localparam int COORD_BITS  = 16;
    localparam int T_FRAC_BITS = 16;
    localparam int OUT_FRAC    = 16;
    localparam int OUT_W       = 40;

    typedef enum logic [1:0] {
        MODE_POS = 2'd0,
        MODE_D1  = 2'd1,
        MODE_D2  = 2'd2,
        MODE_D3  = 2'd3
    } t_mode;

endpackage

`default_nettype wire

>>> sv/crd_in_if.sv
// ----------------------------------------------------------------------------
// crd_in_if
// Input channel: mode, curve parameter and four control values.
// ----------------------------------------------------------------------------
`default_nettype none

interface crd_in_if
    import crd_pkg::*;
#(
    parameter int COORD_BITS  = crd_pkg::COORD_BITS,
    parameter int T_FRAC_BITS = crd_pkg::T_FRAC_BITS
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [T_FRAC_BITS-1:0]        t_frac;
    logic signed [COORD_BITS-1:0]  pt_before;
    logic signed [COORD_BITS-1:0]  pt_start;
    logic signed [COORD_BITS-1:0]  pt_end;
    logic signed [COORD_BITS-1:0]  pt_after;

    modport source (output valid, mode, t_frac, pt_before, pt_start, pt_end, pt_after,
                    input ready);
    modport sink   (input valid, mode, t_frac, pt_before, pt_start, pt_end, pt_after,
                    output ready);
endinterface

`default_nettype wire

>>> sv/crd_out_if.sv
// ----------------------------------------------------------------------------
// crd_out_if
// Output channel: one Q.16 curve value per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface crd_out_if
    import crd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  curve_value;

    modport source (output valid, curve_value, input ready);
    modport sink   (input valid, curve_value, output ready);
endinterface

`default_nettype wire

>>> sv/catmull_rom_derivative_eval_top.sv
// Items pass the coefficient, mode, product, partial-sum, sum and floor stages in order.
// Throughput: one item per cycle; every stage holds its item while the stage after
// it is full and stalled, and an empty stage takes a new item at once.
// The widest multiply is the coefficient times t^2 product in stage three.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// catmull_rom_derivative_eval_top
// Uniform Catmull-Rom segment: position or derivative, exact then floored to Q.16 and clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_derivative_eval_top
    import crd_pkg::*;
#(
    parameter int COORD_BITS  = crd_pkg::COORD_BITS,
    parameter int T_FRAC_BITS = crd_pkg::T_FRAC_BITS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    crd_in_if.sink       i_in,
    crd_out_if.source    o_out
);

    localparam int CB   = COORD_BITS;
    localparam int TB   = T_FRAC_BITS;
    localparam int CW   = CB + 4;              // raw coefficients
    localparam int KW   = CB + 6;              // scaled coefficients, up to 6*c3
    localparam int UUW  = 2 * TB;
    localparam int UUUW = 3 * TB;
    localparam int H    = (3 * TB + 1) / 2;    // low part of t^3 split
    localparam int HH   = 3 * TB - H;
    localparam int P1W  = KW + TB + 1;
    localparam int P2W  = KW + UUW + 1;
    localparam int PLW  = KW + H + 1;
    localparam int PHW  = KW + HH + 1;
    localparam int T3W  = KW + UUUW + 1;
    localparam int AW   = KW + UUUW + 2;
    localparam int SH   = 3 * TB + 1 - OUT_FRAC;
    localparam int SW   = AW - SH;
    localparam int XW   = ((SW > OUT_W) ? SW : OUT_W) + 1;
    localparam int NS   = 6;

    // ---------------- handshake and valid bits ----------------
    logic [NS:1] r_vld;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !r_vld[NS] || o_out.ready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready  = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: coefficients and t^2 ----------------
    logic signed [CW-1:0] p0, p1, p2, p3;
    logic signed [CW-1:0] n_c0, n_c1, n_c2, n_c3;
    logic [UUW-1:0]       n_uu;
    t_mode                r1_mode;
    logic [TB-1:0]        r1_u;
    logic signed [CW-1:0] r1_c0, r1_c1, r1_c2, r1_c3;
    logic [UUW-1:0]       r1_uu;

    always_comb begin
        p0   = CW'(i_in.pt_before);
        p1   = CW'(i_in.pt_start);
        p2   = CW'(i_in.pt_end);
        p3   = CW'(i_in.pt_after);
        n_c0 = p1 <<< 1;
        n_c1 = p2 - p0;
        n_c2 = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
        n_c3 = p1 - p0 + (p1 <<< 1) - (p2 <<< 1) - p2 + p3;
        n_uu = UUW'(i_in.t_frac) * UUW'(i_in.t_frac);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_mode <= t_mode'(i_in.mode);
            r1_u    <= i_in.t_frac;
            r1_c0   <= n_c0;
            r1_c1   <= n_c1;
            r1_c2   <= n_c2;
            r1_c3   <= n_c3;
            r1_uu   <= n_uu;
        end
    end

    // ---------------- stage 2: mode selection and t^3 ----------------
    // All modes share one form: sum of k_i * t^i with 3*TB fraction bits.
    logic signed [KW-1:0] c1x, c2x2, c3x3, c3x6;
    logic signed [KW-1:0] n_k0, n_k1, n_k2, n_k3;
    logic [UUUW-1:0]      n_uuu;
    logic signed [KW-1:0] r2_k0, r2_k1, r2_k2, r2_k3;
    logic [TB-1:0]        r2_u;
    logic [UUW-1:0]       r2_uu;
    logic [UUUW-1:0]      r2_uuu;

    always_comb begin
        c1x   = KW'(r1_c1);
        c2x2  = KW'(r1_c2) <<< 1;
        c3x3  = KW'(r1_c3) + (KW'(r1_c3) <<< 1);
        c3x6  = c3x3 <<< 1;
        n_uuu = UUUW'(r1_uu) * UUUW'(r1_u);
        unique case (r1_mode)
            MODE_POS: begin
                n_k0 = KW'(r1_c0);
                n_k1 = c1x;
                n_k2 = KW'(r1_c2);
                n_k3 = KW'(r1_c3);
            end
            MODE_D1: begin
                n_k0 = c1x;
                n_k1 = c2x2;
                n_k2 = c3x3;
                n_k3 = '0;
            end
            MODE_D2: begin
                n_k0 = c2x2;
                n_k1 = c3x6;
                n_k2 = '0;
                n_k3 = '0;
            end
            MODE_D3: begin
                n_k0 = c3x6;
                n_k1 = '0;
                n_k2 = '0;
                n_k3 = '0;
            end
            default: begin
                n_k0 = '0;
                n_k1 = '0;
                n_k2 = '0;
                n_k3 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_k0  <= n_k0;
            r2_k1  <= n_k1;
            r2_k2  <= n_k2;
            r2_k3  <= n_k3;
            r2_u   <= r1_u;
            r2_uu  <= r1_uu;
            r2_uuu <= n_uuu;
        end
    end

    // ---------------- stage 3: term products ----------------
    logic signed [P1W-1:0] n_t1, r3_t1;
    logic signed [P2W-1:0] n_t2, r3_t2;
    logic signed [PLW-1:0] n_t3lo, r3_t3lo;
    logic signed [PHW-1:0] n_t3hi, r3_t3hi;
    logic signed [KW-1:0]  r3_k0;

    always_comb begin
        n_t1   = P1W'(r2_k1) * P1W'($signed({1'b0, r2_u}));
        n_t2   = P2W'(r2_k2) * P2W'($signed({1'b0, r2_uu}));
        n_t3lo = PLW'(r2_k3) * PLW'($signed({1'b0, r2_uuu[H-1:0]}));
        n_t3hi = PHW'(r2_k3) * PHW'($signed({1'b0, r2_uuu[UUUW-1:H]}));
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_t1   <= n_t1;
            r3_t2   <= n_t2;
            r3_t3lo <= n_t3lo;
            r3_t3hi <= n_t3hi;
            r3_k0   <= r2_k0;
        end
    end

    // ---------------- stage 4: partial sums ----------------
    logic signed [T3W-1:0] n_sa, r4_sa;
    logic signed [AW-1:0]  n_sb, r4_sb;
    logic signed [P2W-1:0] r4_t2;

    always_comb begin
        n_sa = (T3W'(r3_t3hi) <<< H) + T3W'(r3_t3lo);
        n_sb = (AW'(r3_k0) <<< UUUW) + (AW'(r3_t1) <<< UUW);
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_sa <= n_sa;
            r4_sb <= n_sb;
            r4_t2 <= r3_t2;
        end
    end

    // ---------------- stage 5: exact doubled value ----------------
    logic signed [AW-1:0] n_acc, r5_acc;

    always_comb begin
        n_acc = AW'(r4_sa) + r4_sb + (AW'(r4_t2) <<< TB);
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_acc <= n_acc;
        end
    end

    // ---------------- stage 6: floor to Q.16 and clamp ----------------
    // Dropping the low bits of a two's complement value floors it; the extra
    // bit in the shift undoes the doubling of the coefficients.
    logic signed [SW-1:0]    fl_v;
    logic signed [XW-1:0]    ext_v;
    logic                    fits;
    logic signed [OUT_W-1:0] n_out, r_out;

    always_comb begin
        fl_v  = $signed(r5_acc[AW-1:SH]);
        ext_v = XW'(fl_v);
        fits  = (ext_v[XW-1:OUT_W-1] == '0) || (ext_v[XW-1:OUT_W-1] == '1);
        if (fits) begin
            n_out = ext_v[OUT_W-1:0];
        end else if (ext_v[XW-1]) begin
            n_out = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            n_out = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_vld[NS];
    assign o_out.curve_value = r_out;

    // ---------------- assertions ----------------
    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[1])
        else $error("accepted item did not enter the first stage");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_vld))
        else $error("input blocked while the pipeline has a free stage");

    a_out_from_s5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vld[NS]) |-> $past(r_vld[NS-1]))
        else $error("result appeared without an item in the stage before");

    a_d3_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && $past(en[2]) && $past(r1_mode == MODE_D3))
            |-> (r2_k1 == '0 && r2_k2 == '0 && r2_k3 == '0))
        else $error("third derivative carries nonzero higher terms");

endmodule

`default_nettype wire
